@@ design/trg_pkg.sv @@
// ----------------------------------------------------------------------------
// trg_pkg
// Shared types, constants and register codes of the thrust gain estimator.
// ----------------------------------------------------------------------------
package trg_pkg;

  localparam int QUEUE_DEPTH = 100;
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_RECORD   = 2'd0,
    OP_ESTIMATE = 2'd1,
    OP_SAFE     = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGETTING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE    = 3'd5;

  localparam logic [30:0] GRAVITY_RESET    = 31'd642908;
  localparam logic [15:0] HOVER_RESET      = 16'd19661;
  localparam logic [16:0] FORGETTING_RESET = 17'd65405;
  localparam logic [31:0] INIT_COV_RESET   = 32'd1000000;
  localparam logic [15:0] MIN_AGE_RESET    = 16'd35;
  localparam logic [15:0] MAX_AGE_RESET    = 16'd45;
  // Default gravity over default hover throttle, truncated.
  localparam logic signed [31:0] GAIN_RESET = 32'sd2143004;

  // 0.95 in Q0.16.
  localparam logic [15:0] SAFE_SCALE = 16'd62259;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam int MUL_W = 64;
  localparam int DIV_W = 128;

endpackage

@@ design/trg_if.sv @@
// ----------------------------------------------------------------------------
// trg_if
// Valid/ready channels of the thrust gain estimator.
// ----------------------------------------------------------------------------
interface trg_req_if;
  logic              valid;
  logic              ready;
  trg_pkg::op_t      operation;
  logic [31:0]       time_ms;
  logic signed [31:0] collective_accel;
  logic signed [31:0] measured_accel_z;
  modport source (output valid, operation, time_ms, collective_accel, measured_accel_z,
                  input ready);
  modport sink (input valid, operation, time_ms, collective_accel, measured_accel_z,
                output ready);
endinterface

interface trg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] throttle;
  logic signed [31:0] gain_estimate;
  logic               updated;
  logic               saturated;
  modport source (output valid, throttle, gain_estimate, updated, saturated, input ready);
  modport sink (input valid, throttle, gain_estimate, updated, saturated, output ready);
endinterface

interface trg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [trg_pkg::CFG_IDX_W-1:0]      index;
  logic [trg_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/trg_qmem.sv @@
// ----------------------------------------------------------------------------
// trg_qmem
// Sample queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trg_qmem (
  input  logic                   clk,
  input  logic                   we,
  input  logic [trg_pkg::QA_W-1:0] waddr,
  input  logic [63:0]            wdata,
  input  logic                   re,
  input  logic [trg_pkg::QA_W-1:0] raddr,
  output logic [63:0]            rdata
);
  import trg_pkg::*;

  logic [63:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/trg_mul.sv @@
// ----------------------------------------------------------------------------
// trg_mul
// Unsigned 64 x 64 shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module trg_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  import trg_pkg::*;

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic [127:0]     mcand;
  logic [63:0]      mplier;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        prod   <= '0;
        mcand  <= {64'd0, a};
        mplier <= b;
        cnt    <= CNT_W'(MUL_W);
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= {mcand[126:0], 1'b0};
        mplier <= {1'b0, mplier[63:1]};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/trg_div.sv @@
// ----------------------------------------------------------------------------
// trg_div
// Unsigned 128 / 128 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trg_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic [127:0] quo,
  output logic         done
);
  import trg_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [127:0]     rem;
  logic [127:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [128:0]     rem_sh;
  logic [128:0]     diff;
  logic             take;

  always_comb begin
    rem_sh = {rem, quo[127]};
    diff   = rem_sh - {1'b0, dsr};
    take   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= num;
        dsr  <= den;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        rem <= take ? diff[127:0] : rem_sh[127:0];
        quo <= {quo[126:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/thrust_gain_rls_estimator.sv @@
// ----------------------------------------------------------------------------
// thrust_gain_rls_estimator
// Scalar recursive least squares estimate of the thrust-to-acceleration gain
// with a forgetting factor, plus a queue of time-stamped throttle commands.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries
//   req      in         operation, time_ms, collective_accel, measured_accel_z
//   rsp      out        throttle, gain_estimate, updated, saturated
//   cfg      in         register index and write data
//
// One item is worked on at a time. Record, safe and reset mapping use the
// 128-step serial divider. An estimate does one memory read per queue entry
// it inspects and, when it updates, four 64-step multiplies and one 128-step
// divide. Reset is synchronous and loads the register defaults, the gain and
// the covariance; the queue memory needs no clearing pass. A stalled result
// output holds the block at the end of its item; the next item is taken as
// soon as the result register has been handed over.
module thrust_gain_rls_estimator (
  input logic      clk,
  input logic      rst,
  trg_req_if.sink   req,
  trg_rsp_if.source rsp,
  trg_cfg_if.sink   cfg
);
  import trg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SAFE_DIV,
    S_SDIV,
    S_REC_STORE,
    S_EST_READ,
    S_EST_WAIT,
    S_EST_CHECK,
    S_RLS_SQ,
    S_RLS_SQW,
    S_RLS_DW,
    S_RLS_PW,
    S_RLS_K,
    S_RLS_KW,
    S_RLS_GW,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [30:0] gravity;
  logic [15:0] hover;
  logic [16:0] rho;
  logic [31:0] init_cov;
  logic [15:0] min_age;
  logic [15:0] max_age;

  // Estimator state.
  logic signed [31:0] gain;
  logic [63:0]        cov;
  logic [QA_W-1:0]    head;
  logic [QC_W-1:0]    count;

  // Item being worked on.
  op_t                op;
  logic [31:0]        now;
  logic signed [31:0] acc;
  logic signed [31:0] meas;
  logic signed [31:0] thr;
  logic signed [31:0] rls_thr;
  logic [31:0]        athr;
  logic               sat;
  logic               upd;
  logic               div_neg;
  logic [46:0]        safe_num;
  logic signed [63:0] tprod;
  logic               rls_neg;

  // Result register.
  logic               out_valid;
  logic signed [31:0] out_throttle;
  logic signed [31:0] out_gain;
  logic               out_updated;
  logic               out_saturated;

  // Shared arithmetic units.
  logic         mul_start;
  logic [63:0]  mop_a;
  logic [63:0]  mop_b;
  logic [127:0] mul_prod;
  logic         mul_done;
  logic         div_start;
  logic [127:0] dop_n;
  logic [127:0] dop_d;
  logic [127:0] div_quo;
  logic         div_done;

  // Queue memory ports.
  logic            q_we;
  logic [QA_W-1:0] q_waddr;
  logic [63:0]     q_wdata;
  logic            q_re;
  logic [63:0]     q_rdata;

  trg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mop_a),
    .b     (mop_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  trg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dop_n),
    .den   (dop_d),
    .quo   (div_quo),
    .done  (div_done)
  );

  trg_qmem u_qmem (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (head),
    .rdata (q_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.throttle      = out_throttle;
  assign rsp.gain_estimate = out_gain;
  assign rsp.updated       = out_updated;
  assign rsp.saturated     = out_saturated;

  // Head advance with wrap, and the slot a record lands in.
  logic [QA_W-1:0] head_inc;
  logic [QA_W-1:0] rec_head;
  logic [QC_W-1:0] rec_count;
  logic [QC_W:0]   rec_sum;

  always_comb begin
    head_inc = (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    if (count >= QC_W'(QUEUE_DEPTH)) begin
      rec_head  = head_inc;
      rec_count = QC_W'(QUEUE_DEPTH - 1);
    end else begin
      rec_head  = head;
      rec_count = count;
    end
    rec_sum = {{(QC_W + 1 - QA_W){1'b0}}, rec_head} + {1'b0, rec_count};
    if (rec_sum >= (QC_W + 1)'(QUEUE_DEPTH)) begin
      rec_sum = rec_sum - (QC_W + 1)'(QUEUE_DEPTH);
    end
  end

  // Signed quotient with saturation to 32 bits.
  logic signed [31:0] sdiv_res;
  logic               sdiv_sat;

  always_comb begin
    sdiv_res = '0;
    sdiv_sat = 1'b0;
    if (div_neg) begin
      if (div_quo > 128'h8000_0000) begin
        sdiv_res = S32_MIN;
        sdiv_sat = 1'b1;
      end else begin
        sdiv_res = -$signed(div_quo[31:0]);
      end
    end else if (div_quo > 128'h7FFF_FFFF) begin
      sdiv_res = S32_MAX;
      sdiv_sat = 1'b1;
    end else begin
      sdiv_res = $signed(div_quo[31:0]);
    end
  end

  // Age of the head entry as a signed 32-bit difference.
  logic [31:0]        age_raw;
  logic signed [32:0] age;
  logic               too_old;
  logic               too_young;

  always_comb begin
    age_raw   = now - q_rdata[63:32];
    age       = {age_raw[31], age_raw};
    too_old   = age > $signed({17'd0, max_age});
    too_young = age < $signed({17'd0, min_age});
  end

  // RLS intermediate values.
  logic [127:0]       d_val;
  logic [63:0]        kmag;
  logic signed [63:0] err;
  logic [63:0]        aerr;
  logic [63:0]        dmag;
  logic signed [35:0] gsum;

  always_comb begin
    d_val = mul_prod + {63'd0, rho, 48'd0};
    kmag  = (mul_prod[127:80] != '0) ? '1 : mul_prod[79:16];
    err   = {{16{meas[31]}}, meas, 16'd0} - tprod;
    aerr  = err[63] ? -err : err;
    dmag  = (mul_prod[127:112] != '0) ? '1 : mul_prod[111:48];
    if (dmag > 64'h2_0000_0000) begin
      dmag = 64'h2_0000_0000;
    end
    gsum = rls_neg ? 36'(gain) - $signed({2'b00, dmag[33:0]})
                   : 36'(gain) + $signed({2'b00, dmag[33:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gravity   <= GRAVITY_RESET;
      hover     <= HOVER_RESET;
      rho       <= FORGETTING_RESET;
      init_cov  <= INIT_COV_RESET;
      min_age   <= MIN_AGE_RESET;
      max_age   <= MAX_AGE_RESET;
      gain      <= GAIN_RESET;
      cov       <= {INIT_COV_RESET, 32'd0};
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      q_we      <= 1'b0;
      q_re      <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      q_we      <= 1'b0;
      q_re      <= 1'b0;

      // The finish state reloads the result register itself.
      if (rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        case (cfg.index)
          CFG_GRAVITY:    gravity  <= cfg.data[30:0];
          CFG_HOVER:      hover    <= cfg.data[15:0];
          CFG_FORGETTING: rho      <= cfg.data[16:0];
          CFG_INIT_COV:   init_cov <= cfg.data;
          CFG_MIN_AGE:    min_age  <= cfg.data[15:0];
          CFG_MAX_AGE:    max_age  <= cfg.data[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.operation;
            now   <= req.time_ms;
            acc   <= req.collective_accel;
            meas  <= req.measured_accel_z;
            thr   <= '0;
            sat   <= 1'b0;
            upd   <= 1'b0;
            state <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          case (op)
            OP_RECORD: begin
              if (gain == '0) begin
                sat   <= 1'b1;
                thr   <= acc[31] ? S32_MIN : ((acc != '0) ? S32_MAX : '0);
                state <= S_REC_STORE;
              end else begin
                dop_n     <= {80'd0, (acc[31] ? -acc : acc), 16'd0};
                dop_d     <= {96'd0, (gain[31] ? -gain : gain)};
                div_neg   <= acc[31] ^ gain[31];
                div_start <= 1'b1;
                state     <= S_SDIV;
              end
            end
            OP_ESTIMATE: begin
              state <= S_EST_READ;
            end
            OP_SAFE: begin
              if (gain == '0) begin
                sat   <= 1'b1;
                thr   <= (gravity != '0) ? S32_MAX : '0;
                state <= S_FINISH;
              end else begin
                safe_num <= gravity * SAFE_SCALE;
                state    <= S_SAFE_DIV;
              end
            end
            default: begin
              cov   <= {init_cov, 32'd0};
              head  <= '0;
              count <= '0;
              if (hover == '0) begin
                sat   <= 1'b1;
                gain  <= (gravity != '0) ? S32_MAX : '0;
                state <= S_FINISH;
              end else begin
                dop_n     <= {81'd0, gravity, 16'd0};
                dop_d     <= {112'd0, hover};
                div_neg   <= 1'b0;
                div_start <= 1'b1;
                state     <= S_SDIV;
              end
            end
          endcase
        end

        S_SAFE_DIV: begin
          dop_n     <= {81'd0, safe_num};
          dop_d     <= {96'd0, (gain[31] ? -gain : gain)};
          div_neg   <= gain[31];
          div_start <= 1'b1;
          state     <= S_SDIV;
        end

        S_SDIV: begin
          if (div_done) begin
            if (sdiv_sat) begin
              sat <= 1'b1;
            end
            case (op)
              OP_RECORD: begin
                thr   <= sdiv_res;
                state <= S_REC_STORE;
              end
              OP_SAFE: begin
                thr   <= sdiv_res;
                state <= S_FINISH;
              end
              default: begin
                gain  <= sdiv_res;
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_REC_STORE: begin
          q_we    <= 1'b1;
          q_waddr <= rec_sum[QA_W-1:0];
          q_wdata <= {now, thr};
          head    <= rec_head;
          count   <= rec_count + 1'b1;
          state   <= S_FINISH;
        end

        S_EST_READ: begin
          if (count == '0) begin
            state <= S_FINISH;
          end else begin
            q_re  <= 1'b1;
            state <= S_EST_WAIT;
          end
        end

        S_EST_WAIT: begin
          state <= S_EST_CHECK;
        end

        S_EST_CHECK: begin
          if (too_old) begin
            head  <= head_inc;
            count <= count - 1'b1;
            state <= S_EST_READ;
          end else if (too_young) begin
            state <= S_FINISH;
          end else begin
            head    <= head_inc;
            count   <= count - 1'b1;
            upd     <= 1'b1;
            rls_thr <= $signed(q_rdata[31:0]);
            athr    <= q_rdata[31] ? -q_rdata[31:0] : q_rdata[31:0];
            state   <= S_RLS_SQ;
          end
        end

        S_RLS_SQ: begin
          mop_a     <= {32'd0, athr};
          mop_b     <= {32'd0, athr};
          mul_start <= 1'b1;
          state     <= S_RLS_SQW;
        end

        S_RLS_SQW: begin
          if (mul_done) begin
            mop_a     <= cov;
            mop_b     <= mul_prod[63:0];
            mul_start <= 1'b1;
            state     <= S_RLS_DW;
          end
        end

        S_RLS_DW: begin
          if (mul_done) begin
            if (d_val == '0) begin
              sat   <= 1'b1;
              cov   <= '1;
              state <= S_RLS_K;
            end else begin
              dop_n     <= {cov, 64'd0};
              dop_d     <= d_val;
              div_start <= 1'b1;
              state     <= S_RLS_PW;
            end
          end
        end

        S_RLS_PW: begin
          if (div_done) begin
            if (div_quo[127:64] != '0) begin
              sat <= 1'b1;
              cov <= '1;
            end else begin
              cov <= div_quo[63:0];
            end
            state <= S_RLS_K;
          end
        end

        S_RLS_K: begin
          mop_a     <= cov;
          mop_b     <= {32'd0, athr};
          mul_start <= 1'b1;
          tprod     <= rls_thr * gain;
          state     <= S_RLS_KW;
        end

        S_RLS_KW: begin
          if (mul_done) begin
            if (mul_prod[127:80] != '0) begin
              sat <= 1'b1;
            end
            mop_a     <= kmag;
            mop_b     <= aerr;
            rls_neg   <= rls_thr[31] ^ err[63];
            mul_start <= 1'b1;
            state     <= S_RLS_GW;
          end
        end

        S_RLS_GW: begin
          if (mul_done) begin
            if (mul_prod[127:112] != '0) begin
              sat <= 1'b1;
            end
            if (gsum > 36'sh0_7FFF_FFFF) begin
              gain <= S32_MAX;
              sat  <= 1'b1;
            end else if (gsum < -36'sh0_8000_0000) begin
              gain <= S32_MIN;
              sat  <= 1'b1;
            end else begin
              gain <= gsum[31:0];
            end
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid     <= 1'b1;
            out_throttle  <= (op == OP_RECORD || op == OP_SAFE) ? thr : '0;
            out_gain      <= gain;
            out_updated   <= upd;
            out_saturated <= sat;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // The head pointer always addresses a real slot.
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < QA_W'(QUEUE_DEPTH))
    else $error("queue head out of range");

  // An update is only reported for an estimate item.
  a_update_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && upd) |-> (op == OP_ESTIMATE))
    else $error("update flagged outside estimate");

  // Leaving reset the mapping holds its default gain and an empty queue.
  a_reset_state: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (gain == GAIN_RESET && count == '0))
    else $error("reset state not restored");

endmodule
